[hdl/li_pkg.sv]
// Package: shared types, constants and codes for the list intersection block.
`default_nettype none

package li_pkg;

  // Store geometry
  localparam int SET_DEPTH   = 256;
  localparam int VALUE_WIDTH = 32;
  localparam int ADDR_W      = $clog2(SET_DEPTH);
  localparam int FILL_W      = $clog2(SET_DEPTH + 1);

  // Match counter
  localparam int HIT_W = 17;
  localparam logic [HIT_W-1:0] HIT_MAX = {HIT_W{1'b1}};

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_PROBE = 1'b1;

  // Result kind codes
  localparam logic KIND_MATCH = 1'b0;
  localparam logic KIND_END   = 1'b1;

  typedef struct packed {
    logic                          cmd;
    logic signed [VALUE_WIDTH-1:0] item_value;
    logic                          final_element;
  } li_in_t;

  typedef struct packed {
    logic                          item_kind;
    logic signed [VALUE_WIDTH-1:0] match_value;
    logic [HIT_W-1:0]              match_count;
    logic                          overflowed;
    logic                          run_end;
  } li_out_t;

  // Operation decoded by the front end
  typedef enum logic [1:0] {
    OP_LOAD,
    OP_LOAD_NEW,
    OP_PROBE
  } li_op_t;

  typedef struct packed {
    li_op_t                 op;
    logic [VALUE_WIDTH-1:0] value;
    logic                   last;
  } li_entry_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_SCAN,
    BS_EMIT_MATCH,
    BS_EMIT_END
  } li_back_state_t;

endpackage

`default_nettype wire

[hdl/list_intersection.sv]
// Top level: front end, operation queue and back end of the list intersection block.
//
//   channel  direction  handshake              payload
//   in_      input      in_valid / in_ready    li_in_t  (cmd, item_value, final_element)
//   out_     output     out_valid / out_ready  li_out_t (item_kind, match_value,
//                                              match_count, overflowed, run_end)
//
// A probe's search is paced by the single read port of the set store, which is walked
// one entry per cycle and stops at the first match. Reset (rst_n low, synchronous)
// empties the set and marks it closed; store contents are not cleared and need no
// clearing pass. The front end keeps accepting into a two-entry queue while the back
// end searches or a result waits in the output register.
`default_nettype none

module list_intersection
  import li_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire li_in_t in_data,
  output logic        out_valid,
  input  wire logic   out_ready,
  output li_out_t     out_data
);

  logic      push_valid, push_ready;
  li_entry_t push_entry;
  logic      pop_valid, pop_ready;
  li_entry_t pop_entry;

  li_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry)
  );

  li_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_entry (push_entry),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_entry  (pop_entry)
  );

  li_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_entry (pop_entry),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

[hdl/li_front.sv]
// Front end: accepts input items, decodes them and tracks whether the set is closed.
`default_nettype none

module li_front
  import li_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_ready,
  input  wire li_in_t    in_data,
  output logic           push_valid,
  input  wire logic      push_ready,
  output li_entry_t      push_entry
);

  logic      valid_r, valid_nxt;
  logic      closed_r, closed_nxt;
  li_entry_t entry_r, entry_nxt;

  // Take a new item whenever the holding register is empty or drains now
  assign in_ready   = !valid_r || push_ready;
  assign push_valid = valid_r;
  assign push_entry = entry_r;

  // Decode the command and tag loads that must start a fresh set
  always_comb begin
    valid_nxt  = valid_r && !push_ready;
    closed_nxt = closed_r;
    entry_nxt  = entry_r;
    if (in_valid && in_ready) begin
      valid_nxt       = 1'b1;
      entry_nxt.value = in_data.item_value;
      entry_nxt.last  = in_data.final_element;
      if (in_data.cmd == CMD_PROBE) begin
        entry_nxt.op = OP_PROBE;
      end else begin
        entry_nxt.op = closed_r ? OP_LOAD_NEW : OP_LOAD;
        closed_nxt   = in_data.final_element;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      closed_r <= 1'b1;
    end else begin
      valid_r  <= valid_nxt;
      closed_r <= closed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

endmodule

`default_nettype wire

[hdl/li_queue.sv]
// Short queue of decoded operations between front end and back end.
`default_nettype none

module li_queue
  import li_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push_valid,
  output logic           push_ready,
  input  wire li_entry_t push_entry,
  output logic           pop_valid,
  input  wire logic      pop_ready,
  output li_entry_t      pop_entry
);

  li_entry_t         slots_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              do_push, do_pop;

  assign push_ready = (count_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_entry  = slots_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // Advance pointers with wrap and track occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store pushed entries
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

`default_nettype wire

[hdl/li_back.sv]
// Back end: set store, sequential probe search and result register.
`default_nettype none

module li_back
  import li_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      pop_valid,
  output logic           pop_ready,
  input  wire li_entry_t pop_entry,
  output logic           out_valid,
  input  wire logic      out_ready,
  output li_out_t        out_data
);

  // Set store
  logic [VALUE_WIDTH-1:0] store_mem [SET_DEPTH];
  logic [VALUE_WIDTH-1:0] rd_data_r;
  logic                   wr_en, rd_en;
  logic [ADDR_W-1:0]      wr_addr, rd_addr;
  logic [VALUE_WIDTH-1:0] wr_data;

  li_back_state_t         state_r, state_nxt;
  logic [FILL_W-1:0]      fill_r, fill_nxt;
  logic                   lost_r, lost_nxt;
  logic [HIT_W-1:0]       hit_r, hit_nxt;
  logic [VALUE_WIDTH-1:0] value_r, value_nxt;
  logic                   last_r, last_nxt;
  logic [FILL_W-1:0]      idx_r, idx_nxt;
  logic                   cmp_valid_r, cmp_valid_nxt;
  logic                   cmp_last_r, cmp_last_nxt;
  logic                   out_valid_r, out_valid_nxt;
  li_out_t                out_data_r, out_data_nxt;

  logic                   slot_free;
  logic [FILL_W-1:0]      fill_base;

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign slot_free = !out_valid_r || out_ready;

  // Sequence loads, probe scans and result emission
  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    lost_nxt      = lost_r;
    hit_nxt       = hit_r;
    value_nxt     = value_r;
    last_nxt      = last_r;
    idx_nxt       = idx_r;
    cmp_valid_nxt = 1'b0;
    cmp_last_nxt  = cmp_last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    pop_ready     = 1'b0;
    wr_en         = 1'b0;
    rd_en         = 1'b0;
    fill_base     = fill_r;
    wr_addr       = fill_r[ADDR_W-1:0];
    wr_data       = pop_entry.value;
    rd_addr       = idx_r[ADDR_W-1:0];

    unique case (state_r)
      BS_IDLE: begin
        pop_ready = 1'b1;
        if (pop_valid) begin
          case (pop_entry.op) inside
            OP_LOAD, OP_LOAD_NEW: begin
              // Clear the set first when a new one starts
              if (pop_entry.op == OP_LOAD_NEW) begin
                fill_base = '0;
                lost_nxt  = 1'b0;
                hit_nxt   = '0;
              end
              if (fill_base < FILL_W'(SET_DEPTH)) begin
                wr_en    = 1'b1;
                wr_addr  = fill_base[ADDR_W-1:0];
                fill_nxt = fill_base + 1'b1;
              end else begin
                fill_nxt = fill_base;
                lost_nxt = 1'b1;
              end
            end
            OP_PROBE: begin
              value_nxt = pop_entry.value;
              last_nxt  = pop_entry.last;
              idx_nxt   = '0;
              if (fill_r == '0) begin
                state_nxt = pop_entry.last ? BS_EMIT_END : BS_IDLE;
              end else begin
                state_nxt = BS_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      BS_SCAN: begin
        // Compare the entry read last cycle while reading the next one
        if (cmp_valid_r && (rd_data_r == value_r)) begin
          state_nxt = BS_EMIT_MATCH;
        end else if (cmp_valid_r && cmp_last_r) begin
          state_nxt = last_r ? BS_EMIT_END : BS_IDLE;
        end else if (idx_r != fill_r) begin
          rd_en         = 1'b1;
          idx_nxt       = idx_r + 1'b1;
          cmp_valid_nxt = 1'b1;
          cmp_last_nxt  = ((idx_r + 1'b1) == fill_r);
        end
      end

      BS_EMIT_MATCH: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.item_kind   = KIND_MATCH;
          out_data_nxt.match_value = value_r;
          out_data_nxt.match_count = '0;
          out_data_nxt.overflowed  = lost_r;
          out_data_nxt.run_end     = 1'b0;
          hit_nxt   = (hit_r != HIT_MAX) ? hit_r + 1'b1 : hit_r;
          state_nxt = last_r ? BS_EMIT_END : BS_IDLE;
        end
      end

      BS_EMIT_END: begin
        if (slot_free) begin
          out_valid_nxt            = 1'b1;
          out_data_nxt.item_kind   = KIND_END;
          out_data_nxt.match_value = '0;
          out_data_nxt.match_count = hit_r;
          out_data_nxt.overflowed  = lost_r;
          out_data_nxt.run_end     = 1'b1;
          hit_nxt   = '0;
          state_nxt = BS_IDLE;
        end
      end

      default: begin
        state_nxt = BS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BS_IDLE;
      fill_r      <= '0;
      lost_r      <= 1'b0;
      hit_r       <= '0;
      cmp_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      lost_r      <= lost_nxt;
      hit_r       <= hit_nxt;
      cmp_valid_r <= cmp_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r    <= value_nxt;
    last_r     <= last_nxt;
    idx_r      <= idx_nxt;
    cmp_last_r <= cmp_last_nxt;
    out_data_r <= out_data_nxt;
  end

  // Store write and registered read
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= store_mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hdl/li_checker.sv]
// Checker: port-level assertions for the list intersection block, bound to the top level.
`default_nettype none

module li_checker
  import li_pkg::*;
(
  input wire logic    clk,
  input wire logic    rst_n,
  input wire logic    out_valid,
  input wire logic    out_ready,
  input wire li_out_t out_data
);

  // Hold a stalled result
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_data))
    else $error("result changed while stalled");

  // No result right after reset
  assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result shown after reset");

  // End item carries the summary only
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == KIND_END) |->
      out_data.run_end && (out_data.match_value == '0))
    else $error("malformed end item");

  // Match item carries no summary
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.item_kind == KIND_MATCH) |->
      !out_data.run_end && (out_data.match_count == '0))
    else $error("malformed match item");

endmodule

bind list_intersection li_checker u_li_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

[dv/list_intersection_tb.sv]
// Testbench for the list intersection block: directed and random load/probe runs, checked
// against a behavioral copy of the set search.
`timescale 1ns / 100ps

module list_intersection_tb;
  import li_pkg::*;

  localparam int          STALL_LIMIT = 20000;
  localparam int          HOLD_CYCLES = 400;
  localparam logic [31:0] VAL_MIN     = 32'h8000_0000;
  localparam logic [31:0] VAL_MAX     = 32'h7FFF_FFFF;

  logic    clk       = 1'b0;
  logic    rst_n     = 1'b0;
  logic    in_valid  = 1'b0;
  li_in_t  in_data   = '0;
  logic    out_ready = 1'b0;
  logic    in_ready;
  logic    out_valid;
  li_out_t out_data;

  // Idle rates in percent, changed per phase
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int items_sent    = 0;
  int error_count   = 0;
  bit hold_request  = 1'b0;
  int hold_left     = 0;
  int quiet_cycles  = 0;

  // Predicted set state
  logic [31:0]      set_mem [SET_DEPTH];
  int               set_count     = 0;
  bit               set_sealed    = 1'b1;
  logic [HIT_W-1:0] run_hits      = '0;
  bit               loads_dropped = 1'b0;
  li_out_t          awaited_results [$];

  list_intersection dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Update the set state for one accepted item and queue the results it causes
  function automatic void apply_to_set(li_in_t item);
    li_out_t res;
    bit      hit;
    hit = 1'b0;
    if (item.cmd == CMD_LOAD) begin
      if (set_sealed) begin
        set_count     = 0;
        loads_dropped = 1'b0;
        run_hits      = '0;
        set_sealed    = 1'b0;
      end
      if (set_count < SET_DEPTH) begin
        set_mem[set_count] = item.item_value;
        set_count++;
      end else begin
        loads_dropped = 1'b1;
      end
      if (item.final_element) set_sealed = 1'b1;
    end else begin
      for (int j = 0; j < set_count; j++) begin
        if (set_mem[j] == item.item_value) hit = 1'b1;
      end
      if (hit) begin
        if (run_hits != HIT_MAX) run_hits++;
        res             = '0;
        res.item_kind   = KIND_MATCH;
        res.match_value = item.item_value;
        res.overflowed  = loads_dropped;
        awaited_results.push_back(res);
      end
      if (item.final_element) begin
        res             = '0;
        res.item_kind   = KIND_END;
        res.match_count = run_hits;
        res.overflowed  = loads_dropped;
        res.run_end     = 1'b1;
        awaited_results.push_back(res);
        run_hits = '0;
      end
    end
  endfunction

  // Compare one accepted result with the oldest prediction
  function automatic void check_result(li_out_t got);
    li_out_t exp_res;
    if (awaited_results.size() == 0) begin
      error_count++;
      $display("%0t: unexpected result kind=%0d value=%0d count=%0d ovf=%0d end=%0d",
               $time, got.item_kind, got.match_value, got.match_count, got.overflowed,
               got.run_end);
      return;
    end
    exp_res = awaited_results.pop_front();
    if (got.item_kind !== exp_res.item_kind || got.match_value !== exp_res.match_value ||
        got.match_count !== exp_res.match_count || got.overflowed !== exp_res.overflowed ||
        got.run_end !== exp_res.run_end) begin
      error_count++;
      $display("%0t: mismatch expected kind=%0d value=%0d count=%0d ovf=%0d end=%0d, %s",
               $time, exp_res.item_kind, exp_res.match_value, exp_res.match_count,
               exp_res.overflowed, exp_res.run_end,
               $sformatf("got kind=%0d value=%0d count=%0d ovf=%0d end=%0d",
                         got.item_kind, got.match_value, got.match_count,
                         got.overflowed, got.run_end));
    end
  endfunction

  // Receive results, stall at random, and hold off for a long stretch on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left    = HOLD_CYCLES;
      hold_request = 1'b0;
    end
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) check_result(out_data);
      if (hold_left > 0) begin
        hold_left  = hold_left - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // End the run when no transfer happens for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // Offer one item after a random gap and predict once it is accepted
  task automatic send_item(logic cmd, logic [31:0] value, logic last);
    li_in_t item;
    item.cmd           = cmd;
    item.item_value    = value;
    item.final_element = last;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= item;
    @(posedge clk);
    while (in_ready !== 1'b1) @(posedge clk);
    apply_to_set(item);
    items_sent++;
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(3))
      0, 1: return 32'($urandom_range(15)) - 32'd8;
      2: return $urandom;
      default: begin
        case ($urandom_range(3))
          0: return VAL_MIN;
          1: return VAL_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
    endcase
  endfunction

  // Extreme values, duplicates, probes on an empty or open set, fresh set after a closed one
  task automatic test_directed();
    send_item(CMD_PROBE, 32'd0, 1'b0);
    send_item(CMD_PROBE, '1, 1'b1);
    send_item(CMD_LOAD, VAL_MIN, 1'b0);
    send_item(CMD_LOAD, VAL_MAX, 1'b0);
    send_item(CMD_LOAD, 32'd0, 1'b0);
    send_item(CMD_PROBE, VAL_MAX, 1'b0);
    send_item(CMD_LOAD, '1, 1'b0);
    send_item(CMD_LOAD, 32'h5A5A_A5A5, 1'b1);
    send_item(CMD_PROBE, VAL_MIN, 1'b0);
    send_item(CMD_PROBE, VAL_MIN, 1'b0);
    send_item(CMD_PROBE, 32'd0, 1'b0);
    send_item(CMD_PROBE, 32'h5A5A_A5A5, 1'b0);
    send_item(CMD_PROBE, 32'd12345, 1'b0);
    send_item(CMD_PROBE, '1, 1'b1);
    send_item(CMD_PROBE, 32'd7, 1'b1);
    send_item(CMD_LOAD, 32'd42, 1'b1);
    send_item(CMD_PROBE, VAL_MAX, 1'b1);
    send_item(CMD_PROBE, 32'd42, 1'b1);
    send_item(CMD_PROBE, 32'hA5A5_5A5A, 1'b1);
  endtask

  // Overfill the store, with the final mark on a dropped load
  task automatic test_store_full();
    for (int k = 0; k < SET_DEPTH + 3; k++)
      send_item(CMD_LOAD, 32'h1000_0000 + 32'(k), k == SET_DEPTH + 2);
    send_item(CMD_PROBE, 32'h1000_0000, 1'b0);
    send_item(CMD_PROBE, 32'h1000_0000 + 32'(SET_DEPTH - 1), 1'b0);
    send_item(CMD_PROBE, 32'h1000_0000 + 32'(SET_DEPTH), 1'b0);
    send_item(CMD_PROBE, 32'h1000_0005, 1'b1);
  endtask

  // Mostly well-formed runs with random content, some stray items mixed in
  task automatic test_random_runs(int n_items);
    logic [31:0] loaded [$];
    int          stop_at;
    int          set_size;
    int          n_probes;
    logic [31:0] v;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      if ($urandom_range(99) < 15) begin
        send_item(1'($urandom_range(1)), random_value(), 1'($urandom_range(1)));
      end else begin
        if ($urandom_range(9) == 0) set_size = 0;
        else set_size = $urandom_range(12, 1);
        if (set_size > 0) loaded.delete();
        for (int k = 0; k < set_size; k++) begin
          v = random_value();
          loaded.push_back(v);
          send_item(CMD_LOAD, v, k == set_size - 1);
          // probe the open set now and then
          if (k < set_size - 1 && $urandom_range(9) == 0)
            send_item(CMD_PROBE, loaded[$urandom_range(loaded.size() - 1)], 1'b0);
        end
        n_probes = $urandom_range(16, 1);
        for (int p = 0; p < n_probes; p++) begin
          if (loaded.size() > 0 && $urandom_range(99) < 60)
            v = loaded[$urandom_range(loaded.size() - 1)];
          else
            v = random_value();
          send_item(CMD_PROBE, v, p == n_probes - 1);
        end
      end
    end
  endtask

  // Hold the receiver off while matching probes keep coming, so the input stalls
  task automatic test_backpressure();
    for (int k = 0; k < 4; k++) send_item(CMD_LOAD, 32'd100 + 32'(k), k == 3);
    hold_request = 1'b1;
    for (int p = 0; p < 12; p++) send_item(CMD_PROBE, 32'd100 + 32'(p % 4), p == 11);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 29;
    recv_idle_pct = 71;
    test_directed();
    test_store_full();
    test_random_runs(100);

    send_idle_pct = 71;
    recv_idle_pct = 29;
    test_random_runs(100);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_runs(100);
    test_backpressure();

    in_valid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (SET_DEPTH + 8) @(posedge clk);
    if (error_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

[files.f]
hdl/li_pkg.sv
hdl/li_front.sv
hdl/li_queue.sv
hdl/li_back.sv
hdl/list_intersection.sv
hdl/li_checker.sv
dv/list_intersection_tb.sv
